// ----- hdl/cau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int FIELD_WIDTH     = 32;
   localparam int DATA_WIDTH_DEF  = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int OP_WIDTH        = 3;

   typedef logic [OP_WIDTH-1:0] opcode_type;

   localparam opcode_type OP_ADD  = 3'd0;
   localparam opcode_type OP_SUB  = 3'd1;
   localparam opcode_type OP_MUL  = 3'd2;
   localparam opcode_type OP_DIV  = 3'd3;
   localparam opcode_type OP_SQR  = 3'd4;
   localparam opcode_type OP_CONJ = 3'd5;
   localparam opcode_type OP_NEG  = 3'd6;
   localparam opcode_type OP_NONE = 3'd7;

endpackage

// ----- hdl/cau_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_if
// Request and response channel interfaces of the complex arithmetic unit.
// ----------------------------------------------------------------------------
interface cau_req_if import cau_pkg::*; ();
   logic                          valid;
   logic                          ready;
   opcode_type                    opcode;
   logic signed [FIELD_WIDTH-1:0] a_re;
   logic signed [FIELD_WIDTH-1:0] a_im;
   logic signed [FIELD_WIDTH-1:0] b_re;
   logic signed [FIELD_WIDTH-1:0] b_im;

   modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
   modport sink (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if import cau_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [FIELD_WIDTH-1:0] res_re;
   logic signed [FIELD_WIDTH-1:0] res_im;
   logic                          overflow;
   logic                          div_zero;

   modport source (output valid, res_re, res_im, overflow, div_zero, input ready);
   modport sink (input valid, res_re, res_im, overflow, div_zero, output ready);
endinterface

// ----- hdl/cau_mult_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_mult_stage
// Operand register, then the six partial products and the linear results.
// ----------------------------------------------------------------------------
module cau_mult_stage import cau_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  opcode_type                     in_op,
   input  logic signed [DATA_WIDTH-1:0]   in_a_re,
   input  logic signed [DATA_WIDTH-1:0]   in_a_im,
   input  logic signed [DATA_WIDTH-1:0]   in_b_re,
   input  logic signed [DATA_WIDTH-1:0]   in_b_im,
   output logic                           out_valid,
   output opcode_type                     out_op,
   output logic signed [2*DATA_WIDTH-1:0] p0,
   output logic signed [2*DATA_WIDTH-1:0] p1,
   output logic signed [2*DATA_WIDTH-1:0] p2,
   output logic signed [2*DATA_WIDTH-1:0] p3,
   output logic signed [2*DATA_WIDTH-1:0] p4,
   output logic signed [2*DATA_WIDTH-1:0] p5,
   output logic signed [DATA_WIDTH:0]     lin_re,
   output logic signed [DATA_WIDTH:0]     lin_im
);

   localparam int W = DATA_WIDTH;

   logic                   a_valid_ff;
   opcode_type             a_op_ff;
   logic signed [W-1:0]    ar_ff, ai_ff, br_ff, bi_ff;

   logic                   b_valid_ff;
   opcode_type             b_op_ff;
   logic signed [2*W-1:0]  p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [2*W-1:0]  p0_in, p1_in, p2_in, p3_in, p4_in, p5_in;
   logic signed [W:0]      lin_re_ff, lin_im_ff, lin_re_in, lin_im_in;
   logic signed [W-1:0]    mr, mi;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_op_ff   <= in_op;
         ar_ff     <= in_a_re;
         ai_ff     <= in_a_im;
         br_ff     <= in_b_re;
         bi_ff     <= in_b_im;
         b_op_ff   <= a_op_ff;
         p0_ff     <= p0_in;
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         p3_ff     <= p3_in;
         p4_ff     <= p4_in;
         p5_ff     <= p5_in;
         lin_re_ff <= lin_re_in;
         lin_im_ff <= lin_im_in;
      end
   end

   // squaring is a multiply by a itself
   always_comb begin
      mr = (a_op_ff == OP_SQR) ? ar_ff : br_ff;
      mi = (a_op_ff == OP_SQR) ? ai_ff : bi_ff;
      p0_in = ar_ff * mr;
      p1_in = ai_ff * mi;
      p2_in = ar_ff * mi;
      p3_in = ai_ff * mr;
      p4_in = br_ff * br_ff;
      p5_in = bi_ff * bi_ff;
      case (a_op_ff)
         OP_ADD: begin
            lin_re_in = (W+1)'(ar_ff) + (W+1)'(br_ff);
            lin_im_in = (W+1)'(ai_ff) + (W+1)'(bi_ff);
         end
         OP_SUB: begin
            lin_re_in = (W+1)'(ar_ff) - (W+1)'(br_ff);
            lin_im_in = (W+1)'(ai_ff) - (W+1)'(bi_ff);
         end
         OP_CONJ: begin
            lin_re_in = (W+1)'(ar_ff);
            lin_im_in = -(W+1)'(ai_ff);
         end
         OP_NEG: begin
            lin_re_in = -(W+1)'(ar_ff);
            lin_im_in = -(W+1)'(ai_ff);
         end
         default: begin
            lin_re_in = '0;
            lin_im_in = '0;
         end
      endcase
   end

   assign out_valid = b_valid_ff;
   assign out_op    = b_op_ff;
   assign p0        = p0_ff;
   assign p1        = p1_ff;
   assign p2        = p2_ff;
   assign p3        = p3_ff;
   assign p4        = p4_ff;
   assign p5        = p5_ff;
   assign lin_re    = lin_re_ff;
   assign lin_im    = lin_im_ff;

endmodule

// ----- hdl/cau_div_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_step
// One restoring division stage for both quotients; resolves quotient bit SHIFT.
// ----------------------------------------------------------------------------
module cau_div_step #(
   parameter int CW    = 130,
   parameter int DW    = 64,
   parameter int QW    = 34,
   parameter int SW    = 8,
   parameter int SHIFT = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [SW-1:0] in_side,
   input  logic [DW-1:0] in_den,
   input  logic [CW-1:0] in_rem_re,
   input  logic [CW-1:0] in_rem_im,
   input  logic [QW-1:0] in_q_re,
   input  logic [QW-1:0] in_q_im,
   output logic          out_valid,
   output logic [SW-1:0] out_side,
   output logic [DW-1:0] out_den,
   output logic [CW-1:0] out_rem_re,
   output logic [CW-1:0] out_rem_im,
   output logic [QW-1:0] out_q_re,
   output logic [QW-1:0] out_q_im
);

   logic          valid_ff;
   logic [SW-1:0] side_ff;
   logic [DW-1:0] den_ff;
   logic [CW-1:0] rem_re_ff, rem_im_ff, rem_re_in, rem_im_in, dsh;
   logic [QW-1:0] q_re_ff, q_im_ff, q_re_in, q_im_in;

   always_comb begin
      dsh       = CW'(in_den) << SHIFT;
      rem_re_in = in_rem_re;
      rem_im_in = in_rem_im;
      q_re_in   = in_q_re;
      q_im_in   = in_q_im;
      if (in_rem_re >= dsh) begin
         rem_re_in      = in_rem_re - dsh;
         q_re_in[SHIFT] = 1'b1;
      end
      if (in_rem_im >= dsh) begin
         rem_im_in      = in_rem_im - dsh;
         q_im_in[SHIFT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff   <= in_side;
         den_ff    <= in_den;
         rem_re_ff <= rem_re_in;
         rem_im_ff <= rem_im_in;
         q_re_ff   <= q_re_in;
         q_im_ff   <= q_im_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_side   = side_ff;
   assign out_den    = den_ff;
   assign out_rem_re = rem_re_ff;
   assign out_rem_im = rem_im_ff;
   assign out_q_re   = q_re_ff;
   assign out_q_im   = q_im_ff;

endmodule

// ----- hdl/complex_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU on signed fixed-point operands with saturation.
// ----------------------------------------------------------------------------
// Takes one request every cycle while the response side keeps up. Every
// request, whatever its opcode, runs the same DATA_WIDTH + 6 stage pipeline:
// operand register, multipliers, combine, DATA_WIDTH + 2 restoring divider
// stages, then the saturating output register. When a response is held, the
// whole pipeline holds with it.
module complex_arithmetic_unit import cau_pkg::*; #(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   cau_req_if.sink    req_bus,
   cau_rsp_if.source  rsp_bus
);

   localparam int W     = DATA_WIDTH;
   localparam int F     = FRAC_BITS;
   localparam int MW    = 2*W + 1;
   localparam int DW    = 2*W;
   localparam int QW    = W + 2;
   localparam int CW    = 3*W + F + 2;
   localparam int SW    = OP_WIDTH + 2*MW + 3;
   localparam int NSTEP = W + 2;

   localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

   logic en;

   logic                  b_valid;
   opcode_type            b_op;
   logic signed [2*W-1:0] p0, p1, p2, p3, p4, p5;
   logic signed [W:0]     lin_re, lin_im;

   logic          c_valid_ff;
   logic [SW-1:0] c_side_ff, c_side_in;
   logic [DW-1:0] c_den_ff, c_den_in;
   logic [CW-1:0] c_rem_re_ff, c_rem_im_ff, c_rem_re_in, c_rem_im_in;

   logic signed [2*W:0] v_re, v_im;
   logic [MW-1:0]       abs_re, abs_im, mag_re, mag_im;
   logic                neg_re, neg_im, dz;

   logic          s_valid  [0:NSTEP];
   logic [SW-1:0] s_side   [0:NSTEP];
   logic [DW-1:0] s_den    [0:NSTEP];
   logic [CW-1:0] s_rem_re [0:NSTEP];
   logic [CW-1:0] s_rem_im [0:NSTEP];
   logic [QW-1:0] s_q_re   [0:NSTEP];
   logic [QW-1:0] s_q_im   [0:NSTEP];

   opcode_type    f_op;
   logic          f_neg_re, f_neg_im, f_dz;
   logic [MW-1:0] f_mag_re, f_mag_im, sel_re, sel_im;
   logic          ovf_re, ovf_im;
   logic [W-1:0]  sat_re, sat_im;

   logic                          rsp_valid_ff;
   logic signed [FIELD_WIDTH-1:0] res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic                          ovf_ff, ovf_in, dz_ff, dz_in;

   assign en            = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   cau_mult_stage #(.DATA_WIDTH(W)) u_mult (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_bus.valid),
      .in_op     (req_bus.opcode),
      .in_a_re   (req_bus.a_re[W-1:0]),
      .in_a_im   (req_bus.a_im[W-1:0]),
      .in_b_re   (req_bus.b_re[W-1:0]),
      .in_b_im   (req_bus.b_im[W-1:0]),
      .out_valid (b_valid),
      .out_op    (b_op),
      .p0        (p0),
      .p1        (p1),
      .p2        (p2),
      .p3        (p3),
      .p4        (p4),
      .p5        (p5),
      .lin_re    (lin_re),
      .lin_im    (lin_im)
   );

   // combine stage: sign and magnitude of each part, divider operands
   always_comb begin
      case (b_op)
         OP_DIV: begin
            v_re = (2*W+1)'(p0) + (2*W+1)'(p1);
            v_im = (2*W+1)'(p3) - (2*W+1)'(p2);
         end
         OP_MUL, OP_SQR: begin
            v_re = (2*W+1)'(p0) - (2*W+1)'(p1);
            v_im = (2*W+1)'(p2) + (2*W+1)'(p3);
         end
         default: begin
            v_re = (2*W+1)'(lin_re);
            v_im = (2*W+1)'(lin_im);
         end
      endcase
      neg_re = v_re[2*W];
      neg_im = v_im[2*W];
      abs_re = neg_re ? MW'(-v_re) : MW'(v_re);
      abs_im = neg_im ? MW'(-v_im) : MW'(v_im);
      if (b_op == OP_MUL || b_op == OP_SQR) begin
         mag_re = abs_re >> F;
         mag_im = abs_im >> F;
      end else begin
         mag_re = abs_re;
         mag_im = abs_im;
      end
      c_den_in    = DW'(p4) + DW'(p5);
      dz          = (b_op == OP_DIV) && (c_den_in == '0);
      c_rem_re_in = CW'(abs_re) << F;
      c_rem_im_in = CW'(abs_im) << F;
      c_side_in   = {b_op, neg_re, mag_re, neg_im, mag_im, dz};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_side_ff   <= c_side_in;
         c_den_ff    <= c_den_in;
         c_rem_re_ff <= c_rem_re_in;
         c_rem_im_ff <= c_rem_im_in;
      end
   end

   assign s_valid[0]  = c_valid_ff;
   assign s_side[0]   = c_side_ff;
   assign s_den[0]    = c_den_ff;
   assign s_rem_re[0] = c_rem_re_ff;
   assign s_rem_im[0] = c_rem_im_ff;
   assign s_q_re[0]   = '0;
   assign s_q_im[0]   = '0;

   for (genvar k = 0; k < NSTEP; k++) begin : g_div
      cau_div_step #(
         .CW    (CW),
         .DW    (DW),
         .QW    (QW),
         .SW    (SW),
         .SHIFT (NSTEP - 1 - k)
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .in_valid   (s_valid[k]),
         .in_side    (s_side[k]),
         .in_den     (s_den[k]),
         .in_rem_re  (s_rem_re[k]),
         .in_rem_im  (s_rem_im[k]),
         .in_q_re    (s_q_re[k]),
         .in_q_im    (s_q_im[k]),
         .out_valid  (s_valid[k+1]),
         .out_side   (s_side[k+1]),
         .out_den    (s_den[k+1]),
         .out_rem_re (s_rem_re[k+1]),
         .out_rem_im (s_rem_im[k+1]),
         .out_q_re   (s_q_re[k+1]),
         .out_q_im   (s_q_im[k+1])
      );
   end

   // saturation and output register
   always_comb begin
      {f_op, f_neg_re, f_mag_re, f_neg_im, f_mag_im, f_dz} = s_side[NSTEP];
      sel_re = (f_op == OP_DIV) ? MW'(s_q_re[NSTEP]) : f_mag_re;
      sel_im = (f_op == OP_DIV) ? MW'(s_q_im[NSTEP]) : f_mag_im;
      ovf_re = f_neg_re ? (sel_re > (MW'(1) << (W-1)))
                        : (sel_re >= (MW'(1) << (W-1)));
      ovf_im = f_neg_im ? (sel_im > (MW'(1) << (W-1)))
                        : (sel_im >= (MW'(1) << (W-1)));
      if (ovf_re) sat_re = f_neg_re ? SAT_MIN : SAT_MAX;
      else        sat_re = f_neg_re ? W'(-sel_re) : W'(sel_re);
      if (ovf_im) sat_im = f_neg_im ? SAT_MIN : SAT_MAX;
      else        sat_im = f_neg_im ? W'(-sel_im) : W'(sel_im);
      if (f_dz || f_op == OP_NONE) begin
         res_re_in = '0;
         res_im_in = '0;
         ovf_in    = 1'b0;
      end else begin
         res_re_in = FIELD_WIDTH'(signed'(sat_re));
         res_im_in = FIELD_WIDTH'(signed'(sat_im));
         ovf_in    = ovf_re || ovf_im;
      end
      dz_in = f_dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s_valid[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         ovf_ff    <= ovf_in;
         dz_ff     <= dz_in;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.res_re   = res_re_ff;
   assign rsp_bus.res_im   = res_im_ff;
   assign rsp_bus.overflow = ovf_ff;
   assign rsp_bus.div_zero = dz_ff;

`ifndef SYNTHESIS
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && dz_ff |-> res_re_ff == '0 && res_im_ff == '0 && !ovf_ff)
      else $error("division by zero response not cleared");
   a_ovf_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ovf_ff |-> res_re_ff[W-1:0] == SAT_MAX || res_re_ff[W-1:0] == SAT_MIN
         || res_im_ff[W-1:0] == SAT_MAX || res_im_ff[W-1:0] == SAT_MIN)
      else $error("overflow without a saturated part");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |=> rsp_valid_ff && $stable(res_re_ff)
         && $stable(res_im_ff))
      else $error("held response changed");
`endif

endmodule

// ----- tb/cau_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_checker
// Predicts and checks every response of the complex arithmetic unit.
// ----------------------------------------------------------------------------
// Watches both channels. Each accepted request is turned into an expected
// complex result by a fixed-point model held here. Responses are compared
// in order against the oldest expected result.
// ----------------------------------------------------------------------------
module cau_checker import cau_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cau_req_if.sink   req_mon,
   cau_rsp_if.sink   rsp_mon,
   input  logic      req_ready,
   input  logic      rsp_ready,
   output int        error_count,
   output int        pending_count
);

   typedef struct packed {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic               ovf;
      logic               dz;
   } cplx_result_type;

   cplx_result_type expected_results[$];

   localparam logic signed [127:0] MAX_POS = 128'sd2147483647;
   localparam logic signed [127:0] MAX_NEG = -128'sd2147483648;

   // truncate magnitude toward zero by a right shift of FRAC bits
   function automatic logic signed [127:0] trunc_shift(input logic signed [127:0] v);
      logic [127:0] mag;
      begin
         mag = v < 0 ? -v : v;
         mag = mag >> FRAC_BITS_DEF;
         return v < 0 ? -$signed(mag) : $signed(mag);
      end
   endfunction

   function automatic logic signed [127:0] trunc_div(input logic signed [127:0] num,
                                                      input logic [127:0] den);
      logic [127:0] mag;
      begin
         mag = num < 0 ? -num : num;
         mag = (mag << FRAC_BITS_DEF) / den;
         return num < 0 ? -$signed(mag) : $signed(mag);
      end
   endfunction

   function automatic logic signed [31:0] clamp(input logic signed [127:0] v,
                                                inout logic ovf);
      begin
         if (v > MAX_POS) begin
            ovf = 1'b1;
            return 32'sh7fffffff;
         end
         if (v < MAX_NEG) begin
            ovf = 1'b1;
            return 32'sh80000000;
         end
         return v[31:0];
      end
   endfunction

   function automatic cplx_result_type compute_complex(input opcode_type op,
      input logic signed [31:0] ar, ai, br, bi);
      logic signed [127:0] xr, xi, yr, yi, re, im;
      logic [127:0] den;
      cplx_result_type r;
      begin
         xr = ar; xi = ai; yr = br; yi = bi;
         r = '0;
         re = 0; im = 0;
         case (op)
            OP_ADD: begin re = xr + yr; im = xi + yi; end
            OP_SUB: begin re = xr - yr; im = xi - yi; end
            OP_MUL: begin
               re = trunc_shift(xr * yr - xi * yi);
               im = trunc_shift(xr * yi + xi * yr);
            end
            OP_DIV: begin
               den = yr * yr + yi * yi;
               if (den == 0) r.dz = 1'b1;
               else begin
                  re = trunc_div(xr * yr + xi * yi, den);
                  im = trunc_div(xi * yr - xr * yi, den);
               end
            end
            OP_SQR: begin
               re = trunc_shift(xr * xr - xi * xi);
               im = trunc_shift(2 * xr * xi);
            end
            OP_CONJ: begin re = xr; im = -xi; end
            OP_NEG: begin re = -xr; im = -xi; end
            default: ;
         endcase
         r.re = clamp(re, r.ovf);
         r.im = clamp(im, r.ovf);
         return r;
      end
   endfunction

   always @(posedge clock) begin
      cplx_result_type want;
      if (reset) begin
         error_count   <= 0;
         pending_count <= 0;
      end else begin
         if (req_mon.valid && req_ready)
            expected_results.push_back(compute_complex(req_mon.opcode, req_mon.a_re,
               req_mon.a_im, req_mon.b_re, req_mon.b_im));
         if (rsp_mon.valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response %h %h", $time, rsp_mon.res_re,
                        rsp_mon.res_im);
               error_count <= error_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (want.re !== rsp_mon.res_re || want.im !== rsp_mon.res_im ||
                   want.ovf !== rsp_mon.overflow || want.dz !== rsp_mon.div_zero) begin
                  $display("%0t: mismatch expected re=%h im=%h ovf=%b dz=%b",
                           $time, want.re, want.im, want.ovf, want.dz);
                  $display("%0t:          actual re=%h im=%h ovf=%b dz=%b",
                           $time, rsp_mon.res_re, rsp_mon.res_im, rsp_mon.overflow,
                           rsp_mon.div_zero);
                  error_count <= error_count + 1;
               end
            end
         end
         pending_count <= expected_results.size();
      end
   end

endmodule

// ----- tb/complex_arithmetic_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_tb
// Stimulus and verdict for the complex arithmetic unit.
// ----------------------------------------------------------------------------
// Drives directed corner requests for every opcode, then random requests
// with random gaps on both sides and one long response hold-off, and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_tb;
   import cau_pkg::*;

   localparam int NUM_RANDOM = 1530;
   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   int   error_count;
   int   pending_count;
   int   cycle_count;
   int   sent_count;
   bit   hold_done;

   cau_req_if req_bus();
   cau_rsp_if rsp_bus();

   complex_arithmetic_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   cau_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus.sink),
      .rsp_mon       (rsp_bus.sink),
      .req_ready     (req_bus.ready),
      .rsp_ready     (rsp_bus.ready),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int gap_length();
      int p;
      begin
         p = $urandom_range(0, 99);
         if (p < 55) return 0;
         if (p < 92) return $urandom_range(1, 3);
         return $urandom_range(10, 60);
      end
   endfunction

   function automatic logic [31:0] rand_operand();
      begin
         case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h0;
            3: return $urandom_range(0, 65535) << $urandom_range(0, 16);
            4: return -($urandom_range(0, 65535) << $urandom_range(0, 16));
            5: return {{16{1'b0}}, 16'($urandom)} ^ (32'($urandom_range(0, 3)) << 16);
            default: return $urandom;
         endcase
      end
   endfunction

   task automatic send_request(input opcode_type op, input logic [31:0] ar, ai, br, bi);
      begin
         req_bus.valid  <= 1'b1;
         req_bus.opcode <= op;
         req_bus.a_re   <= ar;
         req_bus.a_im   <= ai;
         req_bus.b_re   <= br;
         req_bus.b_im   <= bi;
         do @(posedge clock); while (!req_bus.ready);
         sent_count++;
      end
   endtask

   task automatic idle_cycles(input int n);
      begin
         if (n > 0) begin
            req_bus.valid <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   endtask

   // response side: random stalls, plus one long hold-off
   initial begin
      int n;
      rsp_bus.ready = 1'b0;
      hold_done     = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (!hold_done && sent_count > 300) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (200) @(posedge clock);
         end
         n = $urandom_range(0, 99) < 30 ? gap_length() : 0;
         if (n > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] corner[4];
      int          k;
      corner = '{32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff};
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.opcode = OP_ADD;
      req_bus.a_re   = '0;
      req_bus.a_im   = '0;
      req_bus.b_re   = '0;
      req_bus.b_im   = '0;
      sent_count     = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // opcode sweep on extreme operands, div by zero, unused opcode
      for (int op = 0; op < 8; op++)
         send_request(opcode_type'(op), corner[op % 4], corner[(op + 1) % 4],
                      corner[(op + 2) % 4], corner[(op + 3) % 4]);
      send_request(OP_DIV, 32'h00010000, 32'h00020000, 32'h0, 32'h0);
      send_request(OP_DIV, 32'h80000000, 32'h80000000, 32'h00000001, 32'h0);
      send_request(OP_DIV, 32'h00030000, 32'hfffe0000, 32'h00010000, 32'h00010000);
      send_request(OP_NEG, 32'h80000000, 32'h80000000, 32'h12345678, 32'h9abcdef0);
      send_request(OP_CONJ, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'hffffffff);
      send_request(OP_MUL, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
      send_request(OP_SQR, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0);
      send_request(OP_SQR, 32'hfffe8000, 32'h00018000, 32'hffffffff, 32'h0);
      send_request(OP_SUB, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
      send_request(OP_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
      send_request(OP_MUL, 32'hffff0000, 32'h00008000, 32'h00010001, 32'hfffffffe);

      for (k = 0; k < NUM_RANDOM; k++) begin
         idle_cycles(gap_length());
         send_request(opcode_type'($urandom_range(0, 7)), rand_operand(), rand_operand(),
                      rand_operand(), rand_operand());
      end
      req_bus.valid <= 1'b0;

      wait (pending_count == 0);
      repeat (60) @(posedge clock);
      $display("Sent %0d requests over all opcodes, corners and random operands,", sent_count);
      $display("with random gaps on both channels and one long response hold-off.");
      if (error_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- complex_arithmetic_unit.f -----
hdl/cau_pkg.sv
hdl/cau_if.sv
hdl/cau_mult_stage.sv
hdl/cau_div_step.sv
hdl/complex_arithmetic_unit.sv
tb/cau_checker.sv
tb/complex_arithmetic_unit_tb.sv
